/* hdl/sliding_window_mode_filter_macros.svh */
// Assertion helpers shared by the checker.
`ifndef SLIDING_WINDOW_MODE_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MODE_FILTER_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define SWMF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define SWMF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/swmf_pkg.sv */
package swmf_pkg;

    localparam int PIX_W        = 8;
    localparam int NUM_VALUES   = 256;
    localparam int CFG_WIDTH_W  = 9;
    localparam int CFG_HEIGHT_W = 16;
    localparam int CFG_RADIUS_W = 3;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int OFS_W        = CFG_RADIUS_W + 1;

    localparam logic [CFG_WIDTH_W-1:0]  RST_WIDTH  = 9'd256;
    localparam logic [CFG_HEIGHT_W-1:0] RST_HEIGHT = 16'd256;
    localparam logic [CFG_RADIUS_W-1:0] RST_RADIUS = 3'd4;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_RADIUS = 4;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_WINDOW_RADIUS = 2'd2
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POS,
        ST_CMP,
        ST_PREAD,
        ST_WSET,
        ST_WISSUE,
        ST_WDRAIN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [PIX_W-1:0] value;
    } hist_ctl_t;

endpackage

/* hdl/swmf_line_store.sv */
module swmf_line_store #(
    parameter int DEPTH = 2304,
    parameter int AW    = 12
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic [swmf_pkg::PIX_W-1:0] wdata,
    input  logic                     re,
    input  logic [AW-1:0]            raddr,
    output logic [swmf_pkg::PIX_W-1:0] rdata
);

    logic [swmf_pkg::PIX_W-1:0] mem [DEPTH];
    logic [swmf_pkg::PIX_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/swmf_hist.sv */
module swmf_hist #(
    parameter int CNT_W = 7
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  swmf_pkg::hist_ctl_t         ctl,
    output logic [swmf_pkg::PIX_W-1:0]  mode
);

    logic [CNT_W-1:0]                 cnt_mem [swmf_pkg::NUM_VALUES];
    logic [CNT_W-1:0]                 rd_reg;
    logic                             s2_valid_reg;
    logic [swmf_pkg::PIX_W-1:0]       s2_value_reg;
    logic [swmf_pkg::NUM_VALUES-1:0]  seen_reg;
    logic                             last_wr_reg;
    logic [swmf_pkg::PIX_W-1:0]       last_val_reg;
    logic [CNT_W-1:0]                 last_cnt_reg;
    logic [CNT_W-1:0]                 best_cnt_reg;
    logic [swmf_pkg::PIX_W-1:0]       best_val_reg;
    logic [CNT_W-1:0]                 base;
    logic [CNT_W-1:0]                 cnt_next;
    logic                             better;

    // back-to-back hits on one bin: the read missed last cycle's write
    always_comb begin
        if (last_wr_reg && last_val_reg == s2_value_reg) begin
            base = last_cnt_reg;
        end else if (seen_reg[s2_value_reg]) begin
            base = rd_reg;
        end else begin
            base = '0;
        end
        cnt_next = base + 1'b1;
        // running mode; ties keep the smaller value
        better = (cnt_next > best_cnt_reg) ||
                 (cnt_next == best_cnt_reg && s2_value_reg < best_val_reg);
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg) begin
            cnt_mem[s2_value_reg] <= cnt_next;
        end
        rd_reg <= cnt_mem[ctl.value];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.clear) begin
            s2_valid_reg <= 1'b0;
            s2_value_reg <= '0;
            seen_reg     <= '0;
            last_wr_reg  <= 1'b0;
            last_val_reg <= '0;
            last_cnt_reg <= '0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
        end else begin
            s2_valid_reg <= ctl.valid;
            s2_value_reg <= ctl.value;
            last_wr_reg  <= s2_valid_reg;
            if (s2_valid_reg) begin
                seen_reg[s2_value_reg] <= 1'b1;
                last_val_reg           <= s2_value_reg;
                last_cnt_reg           <= cnt_next;
                if (better) begin
                    best_cnt_reg <= cnt_next;
                    best_val_reg <= s2_value_reg;
                end
            end
        end
    end

    assign mode = best_val_reg;

endmodule

/* hdl/sliding_window_mode_filter.sv */
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tdata[7:0] pixel_in, tuser drain
// m_axis    out  m_axis_tvalid/tready   tdata[7:0] pixel_out, tuser was_filtered,
//                                       tlast last_of_frame
// cfg       in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One word at a time: an item that yields nothing passes IDLE, POS and CMP, a
// border pixel adds PREAD and EMIT, a window pixel WSET, WISSUE, WDRAIN and EMIT;
// in WISSUE the one read port of the line store feeds the histogram one window pixel per cycle.
// aresetn is synchronous; no clearing pass is needed after reset.
// A finished word waits in the output register while the next input word is taken.
module sliding_window_mode_filter #(
    parameter int MAX_WIDTH  = swmf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_RADIUS = swmf_pkg::DEF_MAX_RADIUS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [7:0]                          s_axis_tdata,   // [7:0] pixel_in
    input  logic                                s_axis_tuser,   // [0] drain
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [7:0]                          m_axis_tdata,   // [7:0] pixel_out
    output logic                                m_axis_tuser,   // [0] was_filtered
    output logic                                m_axis_tlast,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [swmf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [swmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int RR    = 2 * MAX_RADIUS + 1;
    localparam int RRW   = $clog2(RR);
    localparam int RRW1  = RRW + 1;
    localparam int DEPTH = RR * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int WW1   = WW + 1;
    localparam int PW    = swmf_pkg::CFG_HEIGHT_W + WW;
    localparam int PW1   = PW + 1;
    localparam int HW1   = swmf_pkg::CFG_HEIGHT_W + 1;
    localparam int CNT_W = $clog2(RR * RR + 1);
    localparam int OW    = swmf_pkg::OFS_W;
    localparam int RW    = swmf_pkg::CFG_RADIUS_W;
    localparam int HW    = swmf_pkg::CFG_HEIGHT_W;
    localparam int XW    = swmf_pkg::PIX_W;

    function automatic logic [AW-1:0] ring_addr(input logic [RRW-1:0] row,
                                                input logic [CW-1:0] col);
        return AW'(row) * AW'(MAX_WIDTH) + AW'(col);
    endfunction

    function automatic logic [RRW-1:0] rr_inc(input logic [RRW-1:0] row);
        return (RRW1'(row) == RRW1'(RR - 1)) ? '0 : row + 1'b1;
    endfunction

    swmf_pkg::state_t state_reg, state_next;

    logic [swmf_pkg::CFG_WIDTH_W-1:0] cfg_width_reg;
    logic [HW-1:0]                    cfg_height_reg;
    logic [RW-1:0]                    cfg_radius_reg;
    logic [PW-1:0]                    total_reg, lag_reg;

    logic [CW-1:0]  in_col_reg, in_col_next, out_col_reg, out_col_next;
    logic [HW-1:0]  in_row_reg, in_row_next, out_row_reg, out_row_next;
    logic [RRW-1:0] in_rr_reg, in_rr_next, out_rr_reg, out_rr_next;
    logic [PW-1:0]  p_reg, p_next, q_reg, q_next;
    logic           done_reg, done_next, filt_reg, filt_next;
    logic [RRW-1:0] wrow_reg, wrow_next;
    logic [CW-1:0]  wcol_reg, wcol_next, wcol0_reg, wcol0_next;
    logic [OW-1:0]  wi_reg, wi_next, wj_reg, wj_next;
    logic           drain_reg, drain_next, issue_d_reg, issue_d_next;
    logic           m_valid_reg, m_valid_next, m_filt_reg, m_filt_next;
    logic           m_last_reg, m_last_next;
    logic [XW-1:0]  m_data_reg, m_data_next;

    logic [WW-1:0]  weff;
    logic [HW-1:0]  heff;
    logic [RW-1:0]  reff;
    logic [OW-1:0]  two_r;
    logic           ready_out, win_end, slot_free;

    logic           ls_we, ls_re;
    logic [AW-1:0]  ls_waddr, ls_raddr;
    logic [XW-1:0]  ls_rdata, mode;
    swmf_pkg::hist_ctl_t hist_ctl;

    logic [WW-1:0]   col_eff, col_inc;
    logic [RRW1-1:0] top_row;

    always_comb begin
        if (cfg_width_reg == '0) begin
            weff = WW'(1);
        end else if (32'(cfg_width_reg) > MAX_WIDTH) begin
            weff = WW'(MAX_WIDTH);
        end else begin
            weff = WW'(cfg_width_reg);
        end
        heff  = (cfg_height_reg == '0) ? HW'(1) : cfg_height_reg;
        reff  = (32'(cfg_radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : cfg_radius_reg;
        two_r = {reff, 1'b0};
    end

    assign ready_out = PW1'(p_reg) >= PW1'(q_reg) + PW1'(lag_reg) + PW1'(1);
    assign win_end   = (wi_reg == two_r) && (wj_reg == two_r);
    assign slot_free = !m_valid_reg || m_axis_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swmf_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = swmf_pkg::ST_POS;
                end
            end
            swmf_pkg::ST_POS: state_next = swmf_pkg::ST_CMP;
            swmf_pkg::ST_CMP: begin
                if (!done_reg && !ready_out) begin
                    state_next = swmf_pkg::ST_IDLE;
                end else if (filt_reg) begin
                    state_next = swmf_pkg::ST_WSET;
                end else begin
                    state_next = swmf_pkg::ST_PREAD;
                end
            end
            swmf_pkg::ST_PREAD: state_next = swmf_pkg::ST_EMIT;
            swmf_pkg::ST_WSET:  state_next = swmf_pkg::ST_WISSUE;
            swmf_pkg::ST_WISSUE: begin
                if (win_end) begin
                    state_next = swmf_pkg::ST_WDRAIN;
                end
            end
            swmf_pkg::ST_WDRAIN: begin
                if (drain_reg) begin
                    state_next = swmf_pkg::ST_EMIT;
                end
            end
            swmf_pkg::ST_EMIT: begin
                if (slot_free) begin
                    state_next = swmf_pkg::ST_IDLE;
                end
            end
            default: state_next = swmf_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        in_rr_next   = in_rr_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        out_rr_next  = out_rr_reg;
        p_next       = p_reg;
        q_next       = q_reg;
        done_next    = done_reg;
        filt_next    = filt_reg;
        wrow_next    = wrow_reg;
        wcol_next    = wcol_reg;
        wcol0_next   = wcol0_reg;
        wi_next      = wi_reg;
        wj_next      = wj_reg;
        drain_next   = 1'b0;
        issue_d_next = 1'b0;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_filt_next  = m_filt_reg;
        m_last_next  = m_last_reg;
        s_axis_tready = 1'b0;
        ls_we    = 1'b0;
        ls_waddr = ring_addr(in_rr_reg, in_col_reg);
        ls_re    = 1'b0;
        ls_raddr = ring_addr(out_rr_reg, out_col_reg);
        hist_ctl.clear = 1'b0;
        hist_ctl.valid = issue_d_reg;
        hist_ctl.value = ls_rdata;
        col_eff = '0;
        col_inc = '0;
        top_row = '0;

        case (state_reg)
            swmf_pkg::ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid && in_row_reg < heff && !s_axis_tuser) begin
                    col_eff  = (WW'(in_col_reg) >= weff) ? '0 : WW'(in_col_reg);
                    col_inc  = col_eff + 1'b1;
                    ls_we    = 1'b1;
                    ls_waddr = ring_addr(in_rr_reg, CW'(col_eff));
                    if (col_inc >= weff) begin
                        in_col_next = '0;
                        in_row_next = in_row_reg + 1'b1;
                        in_rr_next  = rr_inc(in_rr_reg);
                    end else begin
                        in_col_next = CW'(col_inc);
                    end
                end
            end
            swmf_pkg::ST_POS: begin
                col_eff      = (WW'(out_col_reg) >= weff) ? '0 : WW'(out_col_reg);
                out_col_next = CW'(col_eff);
                p_next    = PW'(in_row_reg) * PW'(weff) + PW'(in_col_reg);
                q_next    = PW'(out_row_reg) * PW'(weff) + PW'(col_eff);
                done_next = in_row_reg >= heff;
                filt_next = (out_row_reg >= HW'(reff)) &&
                            (HW1'(out_row_reg) + HW1'(reff) < HW1'(heff)) &&
                            (col_eff >= WW'(reff)) &&
                            (WW1'(col_eff) + WW1'(reff) < WW1'(weff));
            end
            swmf_pkg::ST_PREAD: begin
                ls_re = 1'b1;
            end
            swmf_pkg::ST_WSET: begin
                hist_ctl.clear = 1'b1;
                top_row = RRW1'(out_rr_reg) + RRW1'(RR) - RRW1'(reff);
                if (top_row >= RRW1'(RR)) begin
                    top_row = top_row - RRW1'(RR);
                end
                wrow_next  = RRW'(top_row);
                wcol0_next = out_col_reg - CW'(reff);
                wcol_next  = out_col_reg - CW'(reff);
                wi_next    = '0;
                wj_next    = '0;
            end
            swmf_pkg::ST_WISSUE: begin
                ls_re        = 1'b1;
                ls_raddr     = ring_addr(wrow_reg, wcol_reg);
                issue_d_next = 1'b1;
                if (wj_reg == two_r) begin
                    wj_next   = '0;
                    wcol_next = wcol0_reg;
                    wi_next   = wi_reg + 1'b1;
                    wrow_next = rr_inc(wrow_reg);
                end else begin
                    wj_next   = wj_reg + 1'b1;
                    wcol_next = wcol_reg + 1'b1;
                end
            end
            swmf_pkg::ST_WDRAIN: begin
                drain_next = 1'b1;
            end
            swmf_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = filt_reg ? mode : ls_rdata;
                    m_filt_next  = filt_reg;
                    m_last_next  = PW1'(q_reg) + PW1'(1) >= PW1'(total_reg);
                    if (PW1'(q_reg) + PW1'(1) >= PW1'(total_reg)) begin
                        in_col_next  = '0;
                        in_row_next  = '0;
                        in_rr_next   = '0;
                        out_col_next = '0;
                        out_row_next = '0;
                        out_rr_next  = '0;
                    end else begin
                        col_inc = WW'(out_col_reg) + 1'b1;
                        if (col_inc >= weff) begin
                            out_col_next = '0;
                            out_row_next = out_row_reg + 1'b1;
                            out_rr_next  = rr_inc(out_rr_reg);
                        end else begin
                            out_col_next = CW'(col_inc);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_width_reg  <= swmf_pkg::RST_WIDTH;
            cfg_height_reg <= swmf_pkg::RST_HEIGHT;
            cfg_radius_reg <= swmf_pkg::RST_RADIUS;
        end else if (cfg_valid) begin
            case (cfg_index)
                swmf_pkg::REG_IMAGE_WIDTH: begin
                    cfg_width_reg <= cfg_data[swmf_pkg::CFG_WIDTH_W-1:0];
                end
                swmf_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_height_reg <= cfg_data[HW-1:0];
                end
                swmf_pkg::REG_WINDOW_RADIUS: begin
                    cfg_radius_reg <= cfg_data[RW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // frame size products, following the config registers in the next cycle
    always_ff @(posedge aclk) begin
        total_reg <= PW'(heff) * PW'(weff);
        lag_reg   <= PW'(reff) * PW'(weff) + PW'(reff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swmf_pkg::ST_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            in_rr_reg   <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            out_rr_reg  <= '0;
            drain_reg   <= 1'b0;
            issue_d_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            in_rr_reg   <= in_rr_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            out_rr_reg  <= out_rr_next;
            drain_reg   <= drain_next;
            issue_d_reg <= issue_d_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        p_reg      <= p_next;
        q_reg      <= q_next;
        done_reg   <= done_next;
        filt_reg   <= filt_next;
        wrow_reg   <= wrow_next;
        wcol_reg   <= wcol_next;
        wcol0_reg  <= wcol0_next;
        wi_reg     <= wi_next;
        wj_reg     <= wj_next;
        m_data_reg <= m_data_next;
        m_filt_reg <= m_filt_next;
        m_last_reg <= m_last_next;
    end

    swmf_line_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ls_we),
        .waddr (ls_waddr),
        .wdata (s_axis_tdata),
        .re    (ls_re),
        .raddr (ls_raddr),
        .rdata (ls_rdata)
    );

    swmf_hist #(
        .CNT_W (CNT_W)
    ) u_hist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (hist_ctl),
        .mode    (mode)
    );

    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_filt_reg;
    assign m_axis_tlast  = m_last_reg;

endmodule

/* hdl/swmf_checker.sv */
`include "sliding_window_mode_filter_macros.svh"

module swmf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser,
    input logic       m_axis_tlast,
    input logic       cfg_valid,
    input logic       cfg_ready
);

    // config writes are never back-pressured
    `SWMF_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "cfg write stalled")

    // one word in flight: the input closes right after a word is taken
    `SWMF_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input reopened too early")

    `SWMF_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output word dropped")

    `SWMF_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable({m_axis_tdata, m_axis_tuser, m_axis_tlast}), "output word changed while stalled")

endmodule

bind sliding_window_mode_filter swmf_checker u_swmf_checker (.*);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int LIMIT_CYCLES = 5_000_000;
    localparam int SETTLE = 120;
    localparam int RING_ROWS = 2 * swmf_pkg::DEF_MAX_RADIUS + 1;

    typedef struct packed {
        logic [7:0] pix;
        logic       filt;
        logic       last;
    } out_word_t;

    typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        swmf_pkg::cfg_index_t  idx;
        logic [15:0]           data;
        logic                  drn;
        logic [7:0]            pix;
        logic                  typed;
        out_word_t             want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = '0;
    logic s_axis_tuser = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [swmf_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    always #1 aclk = ~aclk;

    sliding_window_mode_filter DUT (.*);

    // predictor state
    logic [7:0]  ring_mem [RING_ROWS*swmf_pkg::DEF_MAX_WIDTH];
    logic [8:0]  reg_width = swmf_pkg::RST_WIDTH;
    logic [15:0] reg_height = swmf_pkg::RST_HEIGHT;
    logic [2:0]  reg_radius = swmf_pkg::RST_RADIUS;
    int unsigned in_col, in_row, out_col, out_row;
    bit          frame_closed;

    out_word_t   pending_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    bit          no_gaps = 0;

    function automatic int unsigned eff_w();
        return reg_width == 0 ? 1 : (reg_width > swmf_pkg::DEF_MAX_WIDTH ?
                                     swmf_pkg::DEF_MAX_WIDTH : reg_width);
    endfunction

    function automatic int unsigned eff_h();
        return reg_height == 0 ? 1 : reg_height;
    endfunction

    function automatic int unsigned eff_r();
        return reg_radius > swmf_pkg::DEF_MAX_RADIUS ? swmf_pkg::DEF_MAX_RADIUS : reg_radius;
    endfunction

    function automatic int unsigned ring_at(int unsigned row, int unsigned col);
        return (row % RING_ROWS) * swmf_pkg::DEF_MAX_WIDTH + (col % swmf_pkg::DEF_MAX_WIDTH);
    endfunction

    // most frequent value in the window, smallest value on a tie
    function automatic logic [7:0] window_mode(int unsigned y, int unsigned x, int unsigned r);
        int unsigned hist [swmf_pkg::NUM_VALUES];
        int unsigned best, best_n;
        best = 0;
        best_n = 0;
        foreach (hist[i]) hist[i] = 0;
        for (int unsigned yy = y - r; yy <= y + r; yy++)
            for (int unsigned xx = x - r; xx <= x + r; xx++)
                hist[ring_mem[ring_at(yy, xx)]]++;
        for (int v = 0; v < swmf_pkg::NUM_VALUES; v++)
            if (hist[v] > best_n) begin
                best_n = hist[v];
                best = v;
            end
        return best[7:0];
    endfunction

    function automatic bit filter_step(input bit drn, input logic [7:0] px,
                                       output out_word_t res);
        int unsigned w, h, r, total, lag, p, q;
        bit done, filt;
        w = eff_w();
        h = eff_h();
        r = eff_r();
        total = w * h;
        lag = r * w + r;
        res = '0;
        done = in_row >= h;
        if (!done && !drn) begin
            if (in_col >= w) in_col = 0;
            ring_mem[ring_at(in_row, in_col)] = px;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end
        done = in_row >= h;
        if (out_col >= w) out_col = 0;
        p = done ? total : in_row * w + in_col;
        q = out_row * w + out_col;
        if (!done && p < q + lag + 1) return 0;
        filt = out_row >= r && out_row + r < h && out_col >= r && out_col + r < w;
        res.pix = filt ? window_mode(out_row, out_col, r) : ring_mem[ring_at(out_row, out_col)];
        res.filt = filt;
        if (q + 1 >= total) begin
            res.last = 1'b1;
            in_col = 0;
            in_row = 0;
            out_col = 0;
            out_row = 0;
            frame_closed = 1;
        end else begin
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0d] %s: got %0h, expected %0h", cycles, what, got, want);
        errors++;
    endtask

    // sender: bursts of random length separated by random gaps
    task automatic send_word(input bit drn, input logic [7:0] px,
                             input bit typed, input out_word_t want);
        out_word_t res;
        int gap;
        if (burst_left == 0 && !no_gaps) begin
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        s_axis_tuser <= drn;
        do @(posedge aclk); while (!s_axis_tready);
        if (burst_left > 0) burst_left--;
        words_sent++;
        if (filter_step(drn, px, res))
            pending_q.push_back(typed ? want : res);
        else if (typed)
            report_mismatch("predicted no word for typed row", 0, want);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input swmf_pkg::cfg_index_t idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            swmf_pkg::REG_IMAGE_WIDTH:   reg_width = data[8:0];
            swmf_pkg::REG_IMAGE_HEIGHT:  reg_height = data;
            swmf_pkg::REG_WINDOW_RADIUS: reg_radius = data[2:0];
            default: ;
        endcase
    endtask

    // one whole frame, with stray drains inside and stray pixels after it
    task automatic run_frame(input logic [15:0] wd, input logic [15:0] hd,
                             input logic [15:0] rd, input int noise, input bit narrow_vals);
        int unsigned n;
        logic [7:0] px;
        wait_idle();
        write_reg(swmf_pkg::REG_IMAGE_WIDTH, wd);
        write_reg(swmf_pkg::REG_IMAGE_HEIGHT, hd);
        write_reg(swmf_pkg::REG_WINDOW_RADIUS, rd);
        frame_closed = 0;
        n = eff_w() * eff_h();
        for (int unsigned k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise) send_word(1'b1, 8'($urandom), 0, '0);
            px = narrow_vals ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_word(1'b0, px, 0, '0);
        end
        while (!frame_closed)
            send_word($urandom_range(0, 99) >= noise, 8'($urandom), 0, '0);
    endtask

    // receiver stall pattern rotates through four patterns over the run
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("sliding_window_mode_filter: mismatch");
            $finish;
        end
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                report_mismatch("unexpected word", m_axis_tdata, 0);
            end else begin
                if (m_axis_tdata !== pending_q[0].pix)
                    report_mismatch("pixel_out", m_axis_tdata, pending_q[0].pix);
                if (m_axis_tuser !== pending_q[0].filt)
                    report_mismatch("was_filtered", m_axis_tuser, pending_q[0].filt);
                if (m_axis_tlast !== pending_q[0].last)
                    report_mismatch("last_of_frame", m_axis_tlast, pending_q[0].last);
                void'(pending_q.pop_front());
            end
        end
        case ((cycles / 300) % 4)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 1) == 1);
            2: m_axis_tready <= (cycles % 4 == 0);
            default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // 3x3 frame with a three-way tie in the center window (1, 4 and 9 twice)
    dir_row_t dir_rows [] = '{
        '{ROW_CFG,  swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_CFG,  swmf_pkg::REG_IMAGE_HEIGHT,  16'h0000, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_CFG,  swmf_pkg::REG_WINDOW_RADIUS, 16'h0007, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH, 16'h0000, 1'b0, 8'hFF, 1'b1, '{8'hFF, 1'b0, 1'b1}},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b1, 8'h5A, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH, 16'h0000, 1'b0, 8'h00, 1'b1, '{8'h00, 1'b0, 1'b1}},
        '{ROW_CFG,  swmf_pkg::REG_IMAGE_WIDTH,   16'h0003, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_CFG,  swmf_pkg::REG_IMAGE_HEIGHT,  16'h0003, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_CFG,  swmf_pkg::REG_WINDOW_RADIUS, 16'h0001, 1'b0, 8'h00, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b1, 8'h33, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h09, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h09, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h04, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h04, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH, 16'h0000, 1'b0, 8'h07, 1'b1, '{8'h09, 1'b0, 1'b0}},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h01, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h01, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h02, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h03, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'hAA, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b0, 8'h55, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH,   16'h0000, 1'b1, 8'h00, 1'b0, '0},
        '{ROW_WORD, swmf_pkg::REG_IMAGE_WIDTH, 16'h0000, 1'b1, 8'h00, 1'b1, '{8'h03, 1'b0, 1'b1}}
    };

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                wait_idle();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_word(dir_rows[i].drn, dir_rows[i].pix, dir_rows[i].typed,
                          dir_rows[i].want);
            end
        end

        // extremes: widest frame, then one tall column
        run_frame(16'hFFFF, 16'd1, 16'h0000, 5, 1);
        no_gaps = 1;
        run_frame(16'hFE01, 16'd80, 16'h0000, 0, 0);
        no_gaps = 0;
        run_frame(16'd13, 16'd2, 16'd7, 10, 1);
        run_frame(16'd2, 16'd12, 16'd3, 10, 0);
        run_frame(16'd9, 16'd9, 16'd4, 10, 1);

        while (words_sent < 1000)
            run_frame({7'($urandom), 9'($urandom_range(1, 12))},
                      16'($urandom_range(1, 10)),
                      {13'($urandom), 3'($urandom_range(0, 7))},
                      $urandom_range(0, 25), $urandom_range(0, 2) != 0);

        wait_idle();
        if (errors == 0)
            $display("sliding_window_mode_filter: match");
        else
            $display("sliding_window_mode_filter: mismatch");
        $finish;
    end

endmodule

/* sliding_window_mode_filter.f */
+incdir+hdl
hdl/swmf_pkg.sv
hdl/swmf_line_store.sv
hdl/swmf_hist.sv
hdl/sliding_window_mode_filter.sv
hdl/swmf_checker.sv
tb/tb_top.sv
